/* src/ctde_pkg.sv */
// ----------------------------------------------------------------------------
// ctde_pkg: shared types and constants for the clock time digit editor
// Event codes, register map, digit state and result records.
// ----------------------------------------------------------------------------
package ctde_pkg;

  // Event codes carried on the input tuser
  typedef enum logic [2:0] {
    FUNC_START  = 3'd0,
    FUNC_OPTION = 3'd1,
    FUNC_UP     = 3'd2,
    FUNC_DOWN   = 3'd3,
    FUNC_TICK   = 3'd4
  } func_e;

  // Register map (word index taken from paddr[2])
  localparam logic       REG_IDLE_TIMEOUT   = 1'b0;
  localparam logic [15:0] IDLE_TIMEOUT_RESET = 16'd50;

  // Digit limits
  localparam logic [3:0] TOP_HOUR_TENS     = 4'd2;
  localparam logic [3:0] TOP_HOUR_ONES_LOW = 4'd3;
  localparam logic [3:0] TOP_DIGIT         = 4'd9;
  localparam logic [3:0] TOP_MINUTE_TENS   = 4'd5;

  // Edit positions
  localparam logic [1:0] POS_HOUR_TENS   = 2'd0;
  localparam logic [1:0] POS_HOUR_ONES   = 2'd1;
  localparam logic [1:0] POS_MINUTE_TENS = 2'd2;
  localparam logic [1:0] POS_MINUTE_ONES = 2'd3;

  // Editor state
  typedef struct packed {
    logic [1:0]  hour_tens;
    logic [3:0]  hour_ones;
    logic [2:0]  minute_tens;
    logic [3:0]  minute_ones;
    logic [1:0]  position;
    logic        session_open;
    logic [15:0] countdown;
  } edit_state_t;

  // One result item
  typedef struct packed {
    logic [5:0] final_minutes;
    logic [4:0] final_hours;
    logic       timed_out;
    logic       committed;
    logic       editing;
    logic [1:0] edit_position;
    logic [3:0] minute_ones;
    logic [2:0] minute_tens;
    logic [3:0] hour_ones;
    logic [1:0] hour_tens;
  } result_t;

  localparam int unsigned ResultW = $bits(result_t);

endpackage

/* src/ctde_apb.sv */
// ----------------------------------------------------------------------------
// ctde_apb: configuration register block
// Holds the idle timeout register behind a simple APB slave.
// ----------------------------------------------------------------------------
module ctde_apb (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic [15:0] idle_timeout_o
);
  import ctde_pkg::*;

  logic [15:0] timeout_q;
  logic        wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready && (paddr[2] == REG_IDLE_TIMEOUT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= IDLE_TIMEOUT_RESET;
    end else if (wr_en) begin
      timeout_q <= pwdata[15:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_IDLE_TIMEOUT) begin
      prdata = {16'd0, timeout_q};
    end
  end

  assign idle_timeout_o = timeout_q;

endmodule

/* src/ctde_step.sv */
// ----------------------------------------------------------------------------
// ctde_step: next-state and result logic for one event
// Pure combinational: current state plus one request in, new state and result out.
// ----------------------------------------------------------------------------
module ctde_step (
  input  ctde_pkg::edit_state_t state_i,
  input  logic [2:0]            func_i,
  input  logic [4:0]            start_hours_i,
  input  logic [5:0]            start_minutes_i,
  input  logic [15:0]           idle_timeout_i,
  output ctde_pkg::edit_state_t state_o,
  output ctde_pkg::result_t     result_o
);
  import ctde_pkg::*;

  function automatic logic [3:0] digit_step(input logic [3:0] d, input logic [3:0] top,
                                            input logic up);
    logic [3:0] r;
    if (up) begin
      r = (d < top) ? d + 4'd1 : 4'd0;
    end else begin
      r = ((d != 4'd0) && (d <= top)) ? d - 4'd1 : top;
    end
    return r;
  endfunction

  logic [4:0] hrs_sat;
  logic [5:0] min_sat;
  logic [1:0] h_tens;
  logic [4:0] h_ones;
  logic [2:0] m_tens;
  logic [5:0] m_ones;
  logic [3:0] cur_digit;
  logic [3:0] cur_top;
  logic [3:0] new_digit;
  logic [4:0] fh;
  logic [5:0] fm;
  logic       commit;
  logic       timeout;
  edit_state_t nx;

  // Saturate and split the start value into decimal digits
  always_comb begin
    hrs_sat = (start_hours_i > 5'd23) ? 5'd23 : start_hours_i;
    min_sat = (start_minutes_i > 6'd59) ? 6'd59 : start_minutes_i;

    if (hrs_sat >= 5'd20) begin
      h_tens = 2'd2;
      h_ones = hrs_sat - 5'd20;
    end else if (hrs_sat >= 5'd10) begin
      h_tens = 2'd1;
      h_ones = hrs_sat - 5'd10;
    end else begin
      h_tens = 2'd0;
      h_ones = hrs_sat;
    end

    if (min_sat >= 6'd50) begin
      m_tens = 3'd5;
      m_ones = min_sat - 6'd50;
    end else if (min_sat >= 6'd40) begin
      m_tens = 3'd4;
      m_ones = min_sat - 6'd40;
    end else if (min_sat >= 6'd30) begin
      m_tens = 3'd3;
      m_ones = min_sat - 6'd30;
    end else if (min_sat >= 6'd20) begin
      m_tens = 3'd2;
      m_ones = min_sat - 6'd20;
    end else if (min_sat >= 6'd10) begin
      m_tens = 3'd1;
      m_ones = min_sat - 6'd10;
    end else begin
      m_tens = 3'd0;
      m_ones = min_sat;
    end
  end

  // Selected digit and its upper limit
  always_comb begin
    case (state_i.position)
      POS_HOUR_TENS: begin
        cur_digit = {2'd0, state_i.hour_tens};
        cur_top   = TOP_HOUR_TENS;
      end
      POS_HOUR_ONES: begin
        cur_digit = state_i.hour_ones;
        cur_top   = (state_i.hour_tens == 2'd2) ? TOP_HOUR_ONES_LOW : TOP_DIGIT;
      end
      POS_MINUTE_TENS: begin
        cur_digit = {1'b0, state_i.minute_tens};
        cur_top   = TOP_MINUTE_TENS;
      end
      default: begin
        cur_digit = state_i.minute_ones;
        cur_top   = TOP_DIGIT;
      end
    endcase
    new_digit = digit_step(cur_digit, cur_top, func_i == FUNC_UP);
  end

  // Binary value of the digits: x*10 = x*8 + x*2
  assign fh = {state_i.hour_tens, 3'd0} + {2'd0, state_i.hour_tens, 1'b0}
            + {1'b0, state_i.hour_ones};
  assign fm = {state_i.minute_tens, 3'd0} + {2'd0, state_i.minute_tens, 1'b0}
            + {2'd0, state_i.minute_ones};

  always_comb begin
    nx      = state_i;
    commit  = 1'b0;
    timeout = 1'b0;
    case (func_i)
      FUNC_START: begin
        nx.hour_tens    = h_tens;
        nx.hour_ones    = h_ones[3:0];
        nx.minute_tens  = m_tens;
        nx.minute_ones  = m_ones[3:0];
        nx.position     = POS_HOUR_TENS;
        nx.session_open = 1'b1;
        nx.countdown    = idle_timeout_i;
      end
      FUNC_OPTION: begin
        if (state_i.session_open) begin
          nx.countdown = idle_timeout_i;
          if (state_i.position != POS_MINUTE_ONES) begin
            nx.position = state_i.position + 2'd1;
            // clamp hour ones to 3 when entering it under a tens of two
            if ((state_i.position == POS_HOUR_TENS) && (state_i.hour_tens == 2'd2)
                && (state_i.hour_ones > TOP_HOUR_ONES_LOW)) begin
              nx.hour_ones = TOP_HOUR_ONES_LOW;
            end
          end else begin
            commit          = 1'b1;
            nx.session_open = 1'b0;
            nx.position     = POS_HOUR_TENS;
            nx.countdown    = '0;
          end
        end
      end
      FUNC_UP, FUNC_DOWN: begin
        if (state_i.session_open) begin
          nx.countdown = idle_timeout_i;
          case (state_i.position)
            POS_HOUR_TENS:   nx.hour_tens   = new_digit[1:0];
            POS_HOUR_ONES:   nx.hour_ones   = new_digit;
            POS_MINUTE_TENS: nx.minute_tens = new_digit[2:0];
            default:         nx.minute_ones = new_digit;
          endcase
        end
      end
      FUNC_TICK: begin
        if (state_i.session_open) begin
          if (state_i.countdown <= 16'd1) begin
            timeout         = 1'b1;
            nx.session_open = 1'b0;
            nx.position     = POS_HOUR_TENS;
            nx.countdown    = '0;
          end else begin
            nx.countdown = state_i.countdown - 16'd1;
          end
        end
      end
      default: begin
        nx = state_i;
      end
    endcase
  end

  assign state_o = nx;

  always_comb begin
    result_o.hour_tens     = nx.hour_tens;
    result_o.hour_ones     = nx.hour_ones;
    result_o.minute_tens   = nx.minute_tens;
    result_o.minute_ones   = nx.minute_ones;
    result_o.edit_position = nx.session_open ? nx.position : POS_HOUR_TENS;
    result_o.editing       = nx.session_open;
    result_o.committed     = commit;
    result_o.timed_out     = timeout;
    result_o.final_hours   = commit ? fh : 5'd0;
    result_o.final_minutes = commit ? fm : 6'd0;
  end

endmodule

/* src/clock_time_digit_editor.sv */
// ----------------------------------------------------------------------------
// clock_time_digit_editor: HH:MM digit editor for a clock setting menu
// Takes start, option, up, down and tick events and returns the digit state.
// ----------------------------------------------------------------------------
//
// Channel    | Dir | Handshake                  | Payload
// -----------+-----+----------------------------+---------------------------------
// s_axis     | in  | tvalid/tready              | tuser: func; tdata: hours, minutes
// m_axis     | out | tvalid/tready              | tdata: digits, position, flags
// apb        | in  | psel/penable, pready = 1   | idle_timeout_ticks at byte 0
//
// Throughput: one request per cycle sustained while m_axis_tready holds. A
// request is captured in the input register, evaluated against the editor
// state and written into the result register when the result slot is free
// or draining. The editor state register updates in the same cycle as the
// result register, so each request sees everything before it.
// Reset: asynchronous, active low; digits, position, session and countdown
// clear, the timeout register returns to 50.
// Stalls: a held result blocks the evaluation step; the input register still
// takes one request while a result waits, after which tready drops.
// ----------------------------------------------------------------------------
module clock_time_digit_editor (
  input  logic        clk_i,
  input  logic        rst_ni,

  // Request channel
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [2:0]  s_axis_tuser,   // [2:0] func
  input  logic [15:0] s_axis_tdata,   // [4:0] start_hours, [10:5] start_minutes, rest zero

  // Result channel
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [1:0] hour_tens, [5:2] hour_ones, [8:6] minute_tens, [12:9] minute_ones,
  // [14:13] edit_position, [15] editing, [16] committed, [17] timed_out,
  // [22:18] final_hours, [28:23] final_minutes, [31:29] zero
  output logic [31:0] m_axis_tdata,

  // Configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import ctde_pkg::*;

  // Input register
  logic        in_valid_q;
  logic [2:0]  in_func_q;
  logic [4:0]  in_hours_q;
  logic [5:0]  in_minutes_q;

  // Editor state
  edit_state_t state_q;
  edit_state_t state_d;

  // Result register
  logic        out_valid_q;
  result_t     out_q;
  result_t     out_d;

  logic [15:0] idle_timeout;
  logic        advance;

  ctde_apb u_apb (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .idle_timeout_o (idle_timeout)
  );

  ctde_step u_step (
    .state_i         (state_q),
    .func_i          (in_func_q),
    .start_hours_i   (in_hours_q),
    .start_minutes_i (in_minutes_q),
    .idle_timeout_i  (idle_timeout),
    .state_o         (state_d),
    .result_o        (out_d)
  );

  // Evaluate when a request is held and the result slot is free or draining
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_func_q    <= s_axis_tuser;
      in_hours_q   <= s_axis_tdata[4:0];
      in_minutes_q <= s_axis_tdata[10:5];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= out_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(32 - ResultW){1'b0}}, out_q};

endmodule
